// File: rtl/core/hti_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hti_pkg
// shared types and constants for the hash to inverted target pipeline
// ----------------------------------------------------------------------------
package hti_pkg;

  localparam int WORD_W      = 32;
  localparam int HASH_WORDS  = 8;
  localparam int HASH_W      = WORD_W * HASH_WORDS;
  localparam int ZEROS_W     = 10;
  localparam int MANT_W      = 22;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 22;
  localparam int OUT_W       = 32;

  // quotient bits 32 down to 8 are kept
  localparam int DIV_STEPS   = 25;

  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_ZEROS    = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TARGET_MANTISSA = 1'd1;

  localparam logic [ZEROS_W-1:0] TARGET_ZEROS_RESET    = 10'd0;
  localparam logic [MANT_W-1:0]  TARGET_MANTISSA_RESET = 22'd2097152;

  localparam logic [OUT_W-1:0]   FAIL_CODE      = 32'hFFFF_FFFF;
  localparam logic [OUT_W-1:0]   SATURATED_CODE = 32'h0080_0000;
  localparam logic [ZEROS_W-1:0] ZERO_LIMIT     = 10'd255;

  typedef struct packed {
    logic [WORD_W-1:0]    rem;
    logic [WORD_W-1:0]    mant;
    logic [DIV_STEPS-1:0] quot;
    logic [ZEROS_W-1:0]   zeros;
    logic                 fail;
  } div_item_t;

endpackage
`default_nettype wire

// File: rtl/core/hti_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hti_front
// three stage front end: leading word, leading zero count, normalize
// ----------------------------------------------------------------------------
module hti_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          en,
  input  wire logic                          in_valid,
  input  wire logic [hti_pkg::HASH_W-1:0]    hash,
  input  wire logic [hti_pkg::ZEROS_W-1:0]   target_zeros,
  input  wire logic [hti_pkg::MANT_W-1:0]    target_mantissa,
  output logic                               out_valid,
  output hti_pkg::div_item_t                 out_item
);
  import hti_pkg::*;

  function automatic logic [4:0] clz32(input logic [WORD_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) n = 5'(WORD_W - 1 - i);
    end
    return n;
  endfunction

  logic [WORD_W-1:0] w [HASH_WORDS];
  logic [2:0]        lead_next;
  logic              all_zero_next;

  always_comb begin
    for (int k = 0; k < HASH_WORDS; k++) begin
      w[k] = hash[k*WORD_W +: WORD_W];
    end
    lead_next     = '0;
    all_zero_next = 1'b1;
    for (int k = HASH_WORDS - 1; k >= 0; k--) begin
      if (w[k] != '0) begin
        lead_next     = 3'(k);
        all_zero_next = 1'b0;
      end
    end
  end

  // stage 1: leading word pair
  logic              s1_valid;
  logic [2:0]        s1_lead;
  logic              s1_all_zero;
  logic [WORD_W-1:0] s1_hi;
  logic [WORD_W-1:0] s1_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_lead     <= lead_next;
      s1_all_zero <= all_zero_next;
      s1_hi       <= w[lead_next];
      s1_lo       <= (lead_next == 3'(HASH_WORDS - 1)) ? '0 : w[lead_next + 3'd1];
    end
  end

  // stage 2: leading zero count inside the word
  logic              s2_valid;
  logic [2:0]        s2_lead;
  logic              s2_all_zero;
  logic [WORD_W-1:0] s2_hi;
  logic [WORD_W-1:0] s2_lo;
  logic [4:0]        s2_clz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_lead     <= s1_lead;
      s2_all_zero <= s1_all_zero;
      s2_hi       <= s1_hi;
      s2_lo       <= s1_lo;
      s2_clz      <= clz32(s1_hi);
    end
  end

  // stage 3: normalize, zero difference, divider seed
  logic [2*WORD_W-1:0] shifted;
  logic [7:0]          hash_zeros;
  logic [ZEROS_W-1:0]  hash_zeros_ext;
  div_item_t           item_next;

  always_comb begin
    shifted        = {s2_hi, s2_lo} << s2_clz;
    hash_zeros     = {s2_lead, s2_clz};
    hash_zeros_ext = {2'b00, hash_zeros};
    item_next.mant  = shifted[2*WORD_W-1 -: WORD_W];
    // target mantissa << 10, pre-shifted right by one for the first step
    item_next.rem   = {1'b0, target_mantissa, 9'b0};
    item_next.quot  = '0;
    item_next.zeros = target_zeros - hash_zeros_ext;
    item_next.fail  = s2_all_zero || (target_zeros < hash_zeros_ext);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hti_div_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hti_div_step
// one restoring division stage, one quotient bit per stage
// ----------------------------------------------------------------------------
module hti_div_step (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire hti_pkg::div_item_t in_item,
  output logic                    out_valid,
  output hti_pkg::div_item_t      out_item
);
  import hti_pkg::*;

  logic [WORD_W:0]   partial;
  logic [WORD_W+1:0] diff;
  logic              ge;
  div_item_t         item_next;

  always_comb begin
    partial = {in_item.rem, 1'b0};
    diff    = {1'b0, partial} - {2'b00, in_item.mant};
    ge      = ~diff[WORD_W+1];
    item_next       = in_item;
    item_next.rem   = ge ? diff[WORD_W-1:0] : partial[WORD_W-1:0];
    item_next.quot  = {in_item.quot[DIV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hti_pack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hti_pack
// renormalize, build the code, output register with skid buffer
// ----------------------------------------------------------------------------
module hti_pack (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire hti_pkg::div_item_t         in_item,
  output logic                            en,
  output logic                            skid_valid,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [hti_pkg::OUT_W-1:0]       out_data
);
  import hti_pkg::*;

  logic               wide;
  logic [ZEROS_W-1:0] zeros_adj;
  logic [23:0]        mant24;
  logic [OUT_W-1:0]   code;

  always_comb begin
    wide      = in_item.quot[DIV_STEPS-1];
    zeros_adj = wide ? in_item.zeros - 10'd1 : in_item.zeros;
    mant24    = wide ? in_item.quot[DIV_STEPS-1:1] : in_item.quot[DIV_STEPS-2:0];
    if (in_item.fail || (wide && in_item.zeros == '0)) begin
      code = FAIL_CODE;
    end else if (zeros_adj >= ZERO_LIMIT) begin
      code = SATURATED_CODE;
    end else begin
      code = {~zeros_adj[7:0], mant24};
    end
  end

  logic [OUT_W-1:0] skid_data;
  logic             take;
  logic             push;

  assign en   = ~skid_valid;
  assign take = out_valid & out_ready;
  assign push = en & in_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) out_data <= skid_data;
    end else if (push) begin
      if (!out_valid || take) begin
        out_data <= code;
      end else begin
        skid_data <= code;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/hash_to_inverted_target.sv
`timescale 1ns / 1ps
`default_nettype none
// path from the input transfer edge to output tvalid:
//   3 front stages, 25 divider stages of one quotient bit each, output register
// throughput: one hash per cycle unless stalled; the divider is fully pipelined
// reset: synchronous rst clears all valid bits and the skid buffer,
//   target_zeros returns to 0 and target_mantissa to 2097152
// ----------------------------------------------------------------------------
// hash_to_inverted_target
// grades a 256-bit hash against the configured target; unstalled, one per cycle
// ----------------------------------------------------------------------------
module hash_to_inverted_target (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // hash_word_0 .. hash_word_7, 32 bits each
  input  wire logic [hti_pkg::HASH_W-1:0]      s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // inverted_target [31:0]
  output logic [hti_pkg::OUT_W-1:0]            m_axis_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [hti_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [hti_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import hti_pkg::*;

  logic [ZEROS_W-1:0] target_zeros;
  logic [MANT_W-1:0]  target_mantissa;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_zeros    <= TARGET_ZEROS_RESET;
      target_mantissa <= TARGET_MANTISSA_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TARGET_ZEROS:    target_zeros    <= cfg_wdata[ZEROS_W-1:0];
        REG_TARGET_MANTISSA: target_mantissa <= cfg_wdata[MANT_W-1:0];
        default: ;
      endcase
    end
  end

  logic      en;
  logic      skid_valid;
  logic      stage_valid [DIV_STEPS+1];
  div_item_t stage_item  [DIV_STEPS+1];

  assign s_axis_tready = en;

  hti_front u_front (
    .clk             (clk),
    .rst             (rst),
    .en              (en),
    .in_valid        (s_axis_tvalid),
    .hash            (s_axis_tdata),
    .target_zeros    (target_zeros),
    .target_mantissa (target_mantissa),
    .out_valid       (stage_valid[0]),
    .out_item        (stage_item[0])
  );

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    hti_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (stage_valid[g]),
      .in_item   (stage_item[g]),
      .out_valid (stage_valid[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  hti_pack u_pack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (stage_valid[DIV_STEPS]),
    .in_item    (stage_item[DIV_STEPS]),
    .en         (en),
    .skid_valid (skid_valid),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata)
  );

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid buffer holds data while output is empty");

  a_skid_drains_on_transfer: assert property (@(posedge clk) disable iff (rst)
    $fell(skid_valid) |-> $past(m_axis_tvalid && m_axis_tready))
    else $error("skid buffer emptied without an output transfer");

  a_zero_top_byte_saturated: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[31:24] == 8'h00) |-> m_axis_tdata == SATURATED_CODE)
    else $error("zero top byte outside the saturated code");
`endif

endmodule
`default_nettype wire

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for hash_to_inverted_target. Hashes go in on the slave
// stream, and each one's code is predicted from the current target settings.
// The codes coming back are compared in order. A directed table covers the
// all-zero hash, the fail and saturation edges and the mantissa extremes.
// Random phases then sweep the target settings, with bursty input, random
// output stalls and long output hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import hti_pkg::*;

  localparam int MANT_ALIGN   = 10 + 32;
  localparam int WIDE_DROP    = 9;
  localparam int NARROW_DROP  = 8;
  localparam int PHASES       = 7;
  localparam int PHASE_HASHES = 200;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic [ZEROS_W-1:0] zeros;
    logic [MANT_W-1:0]  mant;
    logic [HASH_W-1:0]  hash;
    logic               known;
    logic [OUT_W-1:0]   code;
  } grade_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // hash_word_0 [31:0] .. hash_word_7 [255:224]
  logic [HASH_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // inverted_target [31:0]
  logic [OUT_W-1:0] m_axis_tdata;
  logic cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = REG_TARGET_ZEROS;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [ZEROS_W-1:0] cfg_zeros = TARGET_ZEROS_RESET;
  logic [MANT_W-1:0]  cfg_mant  = TARGET_MANTISSA_RESET;
  logic [OUT_W-1:0]   code_q[$];
  int hashes_sent = 0;
  int codes_seen  = 0;
  int fail_codes  = 0;
  int sat_codes   = 0;
  int settings    = 0;
  int errors      = 0;

  grade_row_t grade_rows [0:DIR_ROWS-1] = '{
    '{10'd0,    22'd2097152,   256'h0,                                  1'b1, FAIL_CODE},
    '{10'd0,    22'd2097152,   {256{1'b1}},                             1'b0, 32'h0},
    '{10'd0,    22'd2097152,   {32'h8000_0000, 224'h0},                 1'b1, FAIL_CODE},
    '{10'd0,    22'd2097152,   {32'h4000_0000, 224'h0},                 1'b1, FAIL_CODE},
    '{10'd0,    22'd2097152,   {32'h0000_0001, 224'h0},                 1'b1, FAIL_CODE},
    '{10'd255,  22'd2097152,   256'h1,                                  1'b1, FAIL_CODE},
    '{10'd256,  22'd2097152,   256'h1,                                  1'b0, 32'h0},
    '{10'd254,  22'd2097152,   256'h1,                                  1'b1, FAIL_CODE},
    '{10'd255,  22'd2097152,   {256{1'b1}},                             1'b1, SATURATED_CODE},
    '{10'd254,  22'd2097152,   {256{1'b1}},                             1'b0, 32'h0},
    '{10'd1023, 22'd2097152,   {256{1'b1}},                             1'b1, SATURATED_CODE},
    '{10'd1023, 22'd2097152,   256'h1,                                  1'b1, SATURATED_CODE},
    '{10'd1023, 22'h3F_FFFF,   {32'h0000_8000, 32'hA5A5_5A5A, 192'h0},  1'b0, 32'h0},
    '{10'd40,   22'd0,         {32'h0000_0001, 224'h0},                 1'b0, 32'h0},
    '{10'd0,    22'h3F_FFFF,   {256{1'b1}},                             1'b0, 32'h0},
    '{10'd1,    22'h3F_FFFF,   {32'h8000_0000, 224'h0},                 1'b0, 32'h0},
    '{10'd1,    22'd2097152,   {32'h8000_0000, 224'h0},                 1'b0, 32'h0},
    '{10'd31,   22'd2097152,   {32'h0000_0001, 32'hFFFF_FFFF, 192'h0},  1'b0, 32'h0},
    '{10'd100,  22'h3F_FFFF,   {96'h0, 32'h0001_2345, 32'h6789_ABCD, 96'h0},
      1'b0, 32'h0},
    '{10'd224,  22'd2097152,   {224'h0, 32'h0000_0003},                 1'b0, 32'h0},
    '{10'd300,  22'h3F_FFFF,   {224'h0, 32'hFFFF_FFFF},                 1'b0, 32'h0},
    '{10'd5,    22'd2097152,   {32'h07FF_FFFF, {224{1'b1}}},            1'b0, 32'h0},
    '{10'd0,    22'd0,         {256{1'b1}},                             1'b0, 32'h0},
    '{10'd0,    22'd2097152,   {32'hFFFF_FFFF, 224'h0},                 1'b0, 32'h0},
    '{10'd0,    22'd2097152,   {32'h8000_0001, {224{1'b1}}},            1'b0, 32'h0}
  };

  hash_to_inverted_target dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // hash is held most significant word first
  function automatic logic [OUT_W-1:0] grade_hash(input logic [HASH_W-1:0] h,
                                                  input logic [ZEROS_W-1:0] tz,
                                                  input logic [MANT_W-1:0] tm);
    logic [WORD_W-1:0] w [HASH_WORDS];
    logic [63:0] pair;
    logic [63:0] quot;
    logic [WORD_W-1:0] mant;
    logic [31:0] diff_w;
    int lead;
    int lz;
    int diff;
    lead = HASH_WORDS;
    for (int k = HASH_WORDS - 1; k >= 0; k--) begin
      w[k] = h[HASH_W-1-WORD_W*k -: WORD_W];
      if (w[k] != '0) lead = k;
    end
    if (lead == HASH_WORDS) return FAIL_CODE;
    lz = 0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[lead][i]) lz = WORD_W - 1 - i;
    end
    pair = {w[lead], (lead < HASH_WORDS - 1) ? w[lead+1] : 32'h0};
    pair = pair << lz;
    mant = pair[63:32];
    lz = WORD_W * lead + lz;
    if (int'(tz) < lz) return FAIL_CODE;
    diff = int'(tz) - lz;
    quot = (64'(tm) << MANT_ALIGN) / 64'(mant);
    if (quot[63:32] != '0) begin
      if (diff == 0) return FAIL_CODE;
      diff--;
      quot = quot >> WIDE_DROP;
    end else begin
      quot = quot >> NARROW_DROP;
    end
    if (diff >= int'(ZERO_LIMIT)) return SATURATED_CODE;
    diff_w = diff;
    return quot[31:0] + (~diff_w << 24);
  endfunction

  // leading zero count is steered around the target so two in five hashes land near the edge
  function automatic logic [HASH_W-1:0] make_hash(input logic [ZEROS_W-1:0] tz);
    logic [HASH_W-1:0] h;
    logic [HASH_W-1:0] below;
    int pick;
    int lz;
    h = {$urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick <= 4) begin
      lz = $urandom_range(0, HASH_W - 1);
    end else if (pick <= 12) begin
      lz = int'(tz) + int'($urandom_range(0, 6)) - 3;
    end else begin
      lz = int'(tz) - int'($urandom_range(0, 280));
    end
    if (lz < 0) lz = 0;
    if (lz > HASH_W - 1) lz = HASH_W - 1;
    h = h >> lz;
    h[HASH_W-1-lz] = 1'b1;
    below = (256'd1 << (HASH_W - 1 - lz)) - 256'd1;
    pick = $urandom_range(0, 7);
    if (pick == 0) h = h & ~below;
    else if (pick == 1) h = h | below;
    return h;
  endfunction

  task automatic push_hash(input logic [HASH_W-1:0] h, input logic known,
                           input logic [OUT_W-1:0] code);
    logic [HASH_W-1:0] packed_words;
    for (int k = 0; k < HASH_WORDS; k++) begin
      packed_words[WORD_W*k +: WORD_W] = h[HASH_W-1-WORD_W*k -: WORD_W];
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_words;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    code_q = {code_q, (known ? code : grade_hash(h, cfg_zeros, cfg_mant))};
    hashes_sent++;
  endtask

  task automatic release_bus(input int cycles);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (cycles - 1) @(negedge clk);
  endtask

  task automatic drain_results();
    release_bus(1);
    while (code_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_target(input logic [ZEROS_W-1:0] tz,
                                input logic [MANT_W-1:0] tm);
    logic [CFG_DATA_W-1:0] zeros_word;
    zeros_word = CFG_DATA_W'($urandom);
    zeros_word[ZEROS_W-1:0] = tz;
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_TARGET_ZEROS;
    cfg_wdata <= zeros_word;
    @(negedge clk);
    cfg_addr  <= REG_TARGET_MANTISSA;
    cfg_wdata <= CFG_DATA_W'(tm);
    @(negedge clk);
    cfg_we    <= 1'b0;
    cfg_zeros = tz;
    cfg_mant  = tm;
    settings++;
  endtask

  always @(posedge clk) begin : code_check
    logic [OUT_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      codes_seen++;
      if (code_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected code transfer, actual %h", $time, m_axis_tdata);
      end else begin
        want = code_q.pop_front();
        if (want == FAIL_CODE) fail_codes++;
        if (want == SATURATED_CODE) sat_codes++;
        if (m_axis_tdata !== want) begin
          errors++;
          $display("%0t: inverted_target mismatch, expected %h actual %h",
                   $time, want, m_axis_tdata);
        end
      end
    end
  end

  // output side: stall pattern plus two long hold-offs while input keeps coming
  initial begin : code_sink
    int stretch_left;
    int stretch_mode;
    int long_holds;
    stretch_left = 0;
    stretch_mode = 0;
    long_holds   = 0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (long_holds < 2 && codes_seen >= 300 + 600 * long_holds) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(negedge clk);
        long_holds++;
      end else begin
        if (stretch_left == 0) begin
          stretch_mode = $urandom_range(0, 2);
          stretch_left = $urandom_range(5, 60);
        end
        stretch_left--;
        case (stretch_mode)
          0:       m_axis_tready <= 1'b1;
          1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : hash_source
    logic [ZEROS_W-1:0] tz;
    logic [MANT_W-1:0] tm;
    int n;
    int burst;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    program_target(TARGET_ZEROS_RESET, TARGET_MANTISSA_RESET);

    for (int r = 0; r < DIR_ROWS; r++) begin
      if (grade_rows[r].zeros != cfg_zeros || grade_rows[r].mant != cfg_mant) begin
        drain_results();
        program_target(grade_rows[r].zeros, grade_rows[r].mant);
      end
      push_hash(grade_rows[r].hash, grade_rows[r].known, grade_rows[r].code);
      if ($urandom_range(0, 2) == 0) release_bus($urandom_range(1, 4));
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          tz = TARGET_ZEROS_RESET;
          tm = TARGET_MANTISSA_RESET;
        end
        1: begin
          tz = '1;
          tm = '1;
        end
        2: begin
          tz = '0;
          tm = '0;
        end
        3: begin
          tz = ZEROS_W'($urandom_range(0, 300));
          tm = {1'b1, 21'($urandom)};
        end
        4: begin
          tz = ZEROS_W'($urandom_range(200, 320));
          tm = MANT_W'($urandom);
        end
        5: begin
          tz = '1;
          tm = '0;
        end
        default: begin
          tz = ZEROS_W'($urandom_range(0, 255));
          tm = '1;
        end
      endcase
      drain_results();
      program_target(tz, tm);
      n = 0;
      while (n < PHASE_HASHES) begin
        burst = $urandom_range(1, 24);
        for (int k = 0; k < burst && n < PHASE_HASHES; k++) begin
          push_hash(make_hash(cfg_zeros), 1'b0, '0);
          n++;
        end
        if ($urandom_range(0, 3) != 0) release_bus($urandom_range(1, 12));
      end
    end

    drain_results();
    repeat (60) @(posedge clk);
    $display("covered %0d hashes over %0d target settings, %0d codes checked",
             hashes_sent, settings, codes_seen);
    $display("fail codes %0d, saturated codes %0d, two long output hold-offs",
             fail_codes, sat_codes);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
